>>> rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, codes and the CRC step for the keyed parameter cache.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int ENTRIES_DEF     = 32;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int VALUE_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [20:0] SECTOR_RST = 21'd131072;
    localparam logic [10:0] HEADER_RST = 11'd32;
    localparam logic [10:0] RECORD_RST = 11'd64;

    typedef enum logic [2:0] {
        REQ_SET    = 3'd0,
        REQ_GET    = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_COMMIT = 3'd3,
        REQ_FORMAT = 3'd4
    } req_code_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_NO_SPACE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_REPLY  = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_HEADER = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SECTOR = 2'd0,
        CFG_HEADER = 2'd1,
        CFG_RECORD = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [20:0] sector_bytes;
        logic [10:0] header_bytes;
        logic [10:0] record_bytes;
    } cfg_t;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        logic [2:0]  req;
        logic [63:0] key;
        logic [3:0]  vtype;
        logic [63:0] value;
        logic [7:0]  dlen;
        logic        klong;
        logic        vlong;
    } item_t;

    // One byte through CRC16-CCITT, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int j = 0; j < 8; j++)
        begin
            if ((r & CRC_MSB) != 16'h0000)
                r = (r << 1) ^ CRC_POLY;
            else
                r = r << 1;
        end
        return r;
    endfunction

endpackage

>>> rtl/kpc_front.sv
// ----------------------------------------------------------------------------
// kpc_front
// Input stage: trims the key at its first zero byte, masks the value and
// flags over-long keys and values.
// ----------------------------------------------------------------------------
module kpc_front #(
    parameter int KEY_BYTES   = kpc_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES = kpc_pkg::VALUE_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [143:0]       s_tdata,
    input  logic [2:0]         s_tuser,
    output logic               push_valid,
    input  logic               push_ready,
    output kpc_pkg::item_t     push_item
);

    logic           hold_valid_reg;
    kpc_pkg::item_t item_reg;
    kpc_pkg::item_t item_next;
    logic [3:0]     klen;
    logic           stop;

    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        klen = 4'd0;
        stop = 1'b0;
        item_next.req   = s_tuser;
        item_next.vtype = s_tdata[67:64];
        item_next.dlen  = s_tdata[139:132];
        item_next.key   = 64'd0;
        item_next.value = 64'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (s_tdata[8*i +: 8] == 8'h00)
                stop = 1'b1;
            if (!stop)
            begin
                item_next.key[8*i +: 8] = s_tdata[8*i +: 8];
                klen = klen + 4'd1;
            end
            if (8'(i) < s_tdata[139:132])
                item_next.value[8*i +: 8] = s_tdata[68+8*i +: 8];
        end
        item_next.klong = (klen >= 4'(KEY_BYTES));
        item_next.vlong = (s_tdata[139:132] > 8'(VALUE_BYTES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (s_tready)
            hold_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= item_next;
    end

endmodule

>>> rtl/kpc_queue.sv
// ----------------------------------------------------------------------------
// kpc_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module kpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  kpc_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_pop,
    output kpc_pkg::item_t rd_item
);

    localparam int PTR_W = (kpc_pkg::QUEUE_DEPTH > 1) ? $clog2(kpc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(kpc_pkg::QUEUE_DEPTH + 1);

    kpc_pkg::item_t slot_reg [kpc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(kpc_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(kpc_pkg::QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(kpc_pkg::QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

>>> rtl/kpc_back.sv
// ----------------------------------------------------------------------------
// kpc_back
// Table, log counters and request sequencer with the output register.
// ----------------------------------------------------------------------------
module kpc_back #(
    parameter int ENTRIES     = kpc_pkg::ENTRIES_DEF,
    parameter int VALUE_BYTES = kpc_pkg::VALUE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  kpc_pkg::cfg_t  cfg,
    input  logic           q_valid,
    output logic           q_pop,
    input  kpc_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [247:0]   m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int PROD_W = CNT_W + 11;
    localparam int BC_W   = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MATCH, S_DECIDE, S_GETWAIT, S_MUL, S_CHECK,
        S_SCAN, S_RDWAIT, S_CRC, S_EMIT
    } state_t;

    state_t             state_reg;
    state_t             ret_reg;
    kpc_pkg::item_t     cur_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] dirty_reg;
    logic [ENTRIES-1:0] match_reg;
    logic [63:0]        key_reg [ENTRIES];
    logic [71:0]        mem [ENTRIES];
    logic [71:0]        rd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [20:0]        lo_reg;
    logic [31:0]        hw_reg;
    logic [15:0]        ar_reg;
    logic [20:0]        cur_off_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [BC_W-1:0]    bc_reg;
    logic [15:0]        crc_reg;
    logic [2:0]         r_status_reg;
    logic [1:0]         r_kind_reg;
    logic [63:0]        r_key_reg;
    logic [3:0]         r_type_reg;
    logic [3:0]         r_len_reg;
    logic [63:0]        r_val_reg;
    logic [20:0]        r_off_reg;
    logic [15:0]        r_crc_reg;
    logic               r_last_reg;
    logic               m_tvalid_reg;
    logic [247:0]       m_tdata_reg;
    logic [1:0]         m_tuser_reg;
    logic               m_tlast_reg;

    logic [ENTRIES-1:0] match_c;
    logic [IDX_W-1:0]   mslot;
    logic [IDX_W-1:0]   fslot;
    logic               mhit;
    logic               fhit;
    logic [IDX_W-1:0]   set_slot;
    logic [IDX_W-1:0]   sidx;
    logic               scan_end;
    logic               scan_hit;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [20:0]        free_c;
    logic [31:0]        need_c;
    logic [15:0]        crc_c;
    logic               load_out;
    logic               set_ok;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign sidx     = idx_reg[IDX_W-1:0];
    assign scan_end = (idx_reg == CNT_W'(ENTRIES));
    assign scan_hit = !scan_end && valid_reg[sidx] && dirty_reg[sidx];
    assign free_c   = (lo_reg >= cfg.sector_bytes) ? 21'd0 : cfg.sector_bytes - lo_reg;
    assign need_c   = 32'(prod_reg) + 32'(cfg.header_bytes);
    assign crc_c    = kpc_pkg::crc_byte(crc_reg, rd_reg[8*bc_reg +: 8]);
    assign load_out = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign set_ok   = !cur_reg.klong && !cur_reg.vlong && (mhit || fhit);
    assign set_slot = mhit ? mslot : fslot;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
            match_c[i] = valid_reg[i] && (key_reg[i] == cur_reg.key);
    end

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        mslot = '0;
        fslot = '0;
        mhit  = 1'b0;
        fhit  = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                mslot = IDX_W'(i);
                mhit  = 1'b1;
            end
            if (!valid_reg[i])
            begin
                fslot = IDX_W'(i);
                fhit  = 1'b1;
            end
        end
    end

    always_comb
    begin
        mem_we    = (state_reg == S_DECIDE) && (cur_reg.req == kpc_pkg::REQ_SET) && set_ok;
        mem_re    = 1'b0;
        mem_raddr = mslot;
        if (state_reg == S_SCAN)
        begin
            mem_re    = scan_hit;
            mem_raddr = sidx;
        end
        else if (state_reg == S_DECIDE)
            mem_re = (cur_reg.req == kpc_pkg::REQ_GET) && !cur_reg.klong && mhit;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[set_slot]     <= {cur_reg.vtype, cur_reg.dlen[3:0], cur_reg.value};
            key_reg[set_slot] <= cur_reg.key;
        end
        if (mem_re)
            rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            lo_reg       <= 21'(kpc_pkg::HEADER_RST);
            hw_reg       <= 32'd0;
            ar_reg       <= 16'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_item;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    match_reg <= match_c;
                    cnt_reg   <= CNT_W'($countones(valid_reg & dirty_reg));
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    // Default: a single plain reply.
                    r_status_reg <= kpc_pkg::ST_OK;
                    r_kind_reg   <= kpc_pkg::KIND_REPLY;
                    r_key_reg    <= 64'd0;
                    r_type_reg   <= 4'd0;
                    r_len_reg    <= 4'd0;
                    r_val_reg    <= 64'd0;
                    r_off_reg    <= 21'd0;
                    r_crc_reg    <= 16'd0;
                    r_last_reg   <= 1'b1;
                    ret_reg      <= S_IDLE;
                    state_reg    <= S_EMIT;
                    case (cur_reg.req)
                        kpc_pkg::REQ_SET:
                        begin
                            if (cur_reg.klong || cur_reg.vlong)
                                r_status_reg <= kpc_pkg::ST_INVALID;
                            else if (!(mhit || fhit))
                                r_status_reg <= kpc_pkg::ST_FULL;
                            else
                            begin
                                valid_reg[set_slot] <= 1'b1;
                                dirty_reg[set_slot] <= 1'b1;
                            end
                        end
                        kpc_pkg::REQ_GET:
                        begin
                            if (cur_reg.klong || !mhit)
                                r_status_reg <= kpc_pkg::ST_NOT_FOUND;
                            else
                                state_reg <= S_GETWAIT;
                        end
                        kpc_pkg::REQ_DELETE:
                        begin
                            if (cur_reg.klong || !mhit)
                                r_status_reg <= kpc_pkg::ST_NOT_FOUND;
                            else
                            begin
                                valid_reg[mslot] <= 1'b0;
                                dirty_reg[mslot] <= 1'b0;
                            end
                        end
                        kpc_pkg::REQ_COMMIT:
                        begin
                            if (cnt_reg != '0)
                                state_reg <= S_MUL;
                        end
                        kpc_pkg::REQ_FORMAT:
                        begin
                            valid_reg  <= '0;
                            dirty_reg  <= '0;
                            lo_reg     <= 21'(cfg.header_bytes);
                            hw_reg     <= 32'd1;
                            ar_reg     <= 16'd0;
                            r_kind_reg <= kpc_pkg::KIND_HEADER;
                        end
                        default:
                            r_status_reg <= kpc_pkg::ST_INVALID;
                    endcase
                end
                S_GETWAIT:
                begin
                    r_type_reg <= rd_reg[71:68];
                    r_len_reg  <= rd_reg[67:64];
                    r_val_reg  <= rd_reg[63:0];
                    state_reg  <= S_EMIT;
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(cnt_reg) * PROD_W'(cfg.record_bytes);
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (32'(free_c) < need_c)
                    begin
                        r_status_reg <= kpc_pkg::ST_NO_SPACE;
                        state_reg    <= S_EMIT;
                    end
                    else
                    begin
                        // Counters jump to their final values; records use cur_off.
                        lo_reg      <= lo_reg + 21'(prod_reg);
                        hw_reg      <= hw_reg + 32'd1;
                        ar_reg      <= ar_reg + 16'(cnt_reg);
                        cur_off_reg <= lo_reg;
                        idx_reg     <= '0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_end)
                    begin
                        r_status_reg <= kpc_pkg::ST_OK;
                        r_kind_reg   <= kpc_pkg::KIND_HEADER;
                        r_key_reg    <= 64'd0;
                        r_type_reg   <= 4'd0;
                        r_len_reg    <= 4'd0;
                        r_val_reg    <= 64'd0;
                        r_off_reg    <= 21'd0;
                        r_crc_reg    <= 16'd0;
                        r_last_reg   <= 1'b1;
                        ret_reg      <= S_IDLE;
                        state_reg    <= S_EMIT;
                    end
                    else if (scan_hit)
                    begin
                        dirty_reg[sidx] <= 1'b0;
                        r_key_reg       <= key_reg[sidx];
                        state_reg       <= S_RDWAIT;
                    end
                    else
                        idx_reg <= idx_reg + CNT_W'(1);
                end
                S_RDWAIT:
                begin
                    crc_reg   <= kpc_pkg::CRC_INIT;
                    bc_reg    <= '0;
                    state_reg <= S_CRC;
                end
                S_CRC:
                begin
                    crc_reg <= crc_c;
                    if (bc_reg == BC_W'(VALUE_BYTES - 1))
                    begin
                        r_status_reg <= kpc_pkg::ST_OK;
                        r_kind_reg   <= kpc_pkg::KIND_RECORD;
                        r_type_reg   <= rd_reg[71:68];
                        r_len_reg    <= rd_reg[67:64];
                        r_val_reg    <= rd_reg[63:0];
                        r_off_reg    <= cur_off_reg;
                        r_crc_reg    <= crc_c;
                        r_last_reg   <= 1'b0;
                        cur_off_reg  <= cur_off_reg + 21'(cfg.record_bytes);
                        idx_reg      <= idx_reg + CNT_W'(1);
                        ret_reg      <= S_SCAN;
                        state_reg    <= S_EMIT;
                    end
                    else
                        bc_reg <= bc_reg + BC_W'(1);
                end
                S_EMIT:
                begin
                    if (load_out)
                        state_reg <= ret_reg;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= {3'd0, free_c, ar_reg, hw_reg, r_crc_reg, r_off_reg,
                            r_val_reg, r_len_reg, r_type_reg, r_key_reg, r_status_reg};
            m_tuser_reg <= r_kind_reg;
            m_tlast_reg <= r_last_reg;
        end
    end

endmodule

>>> rtl/keyed_param_cache_with_commit.sv
// ----------------------------------------------------------------------------
// keyed_param_cache_with_commit
// Key-value parameter cache with commit to an append-only record log.
// ----------------------------------------------------------------------------
// A request enters on the s_ stream and is trimmed and checked by the front
// stage, waits in a two-entry queue, and is carried out by a sequencer that
// owns the table and the log counters; results leave through a registered
// m_ stream, m_tlast marking the last result of each request. A request
// passes the front register and the queue write before it reaches the
// sequencer. Set and delete pass through pop, match, decide and result
// load; get adds the registered memory read. Commit passes pop, match and
// dirty count, decide, multiply and space check; a commit with nothing dirty
// goes from decide to the result load, and one without room from the check.
// A commit that goes ahead then scans the table slot by slot; each dirty
// entry adds a memory read, the byte-serial CRC over its value bytes and a
// record load, the CRC unit sitting behind the single value memory read
// port, and the end of the scan brings the header update. Format and
// unknown requests pass through pop, match, decide and result load.
// Output stalls hold the sequencer; the front keeps taking transactions
// until the queue fills.
// ----------------------------------------------------------------------------
module keyed_param_cache_with_commit #(
    parameter int ENTRIES     = kpc_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES   = kpc_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES = kpc_pkg::VALUE_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key[63:0], value_type[67:64], value[131:68], byte_count[139:132]
    input  logic [143:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], key_out[66:3], type_out[70:67], len_out[74:71],
    // value_out[138:75], record_offset[159:139], value_crc[175:160],
    // write_count[207:176], log_records[223:208], free_space[244:224]
    output logic [247:0] m_tdata,
    // result_kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [20:0]  cfg_data
);

    kpc_pkg::cfg_t  cfg_reg;
    logic           push_valid;
    logic           push_ready;
    kpc_pkg::item_t push_item;
    logic           q_valid;
    logic           q_pop;
    kpc_pkg::item_t q_item;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sector_bytes <= kpc_pkg::SECTOR_RST;
            cfg_reg.header_bytes <= kpc_pkg::HEADER_RST;
            cfg_reg.record_bytes <= kpc_pkg::RECORD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kpc_pkg::CFG_SECTOR: cfg_reg.sector_bytes <= cfg_data;
                kpc_pkg::CFG_HEADER: cfg_reg.header_bytes <= cfg_data[10:0];
                kpc_pkg::CFG_RECORD: cfg_reg.record_bytes <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    kpc_front #(
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    kpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    kpc_back #(
        .ENTRIES     (ENTRIES),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A header update always closes its request.
    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == kpc_pkg::KIND_HEADER) |-> m_tlast)
        else $error("header update not marked last");

    // A log record is never last and always ok.
    a_record_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == kpc_pkg::KIND_RECORD)
        |-> !m_tlast && (m_tdata[2:0] == kpc_pkg::ST_OK))
        else $error("log record marked last or failed");

    // A plain reply is the only result of its request.
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == kpc_pkg::KIND_REPLY) |-> m_tlast)
        else $error("reply not marked last");

endmodule
